### design/nrmc_pkg.sv
// Shared types, constants and helpers for the RMC checksum and time parser.
package nrmc_pkg;

  localparam int HDR_LEN     = 7;
  localparam int TIME_FIRST  = 7;
  localparam int TIME_DIGITS = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] POS_MAX    = 4'd15;
  localparam logic [4:0] ZONE_RESET = 5'd8;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ACTIVE = 8'h41;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;

  // comma tracker: 3 means the status byte has been taken
  localparam logic [1:0] CC_STATUS = 2'd2;
  localparam logic [1:0] CC_DONE   = 2'd3;

  // one finished sentence, handed from the scanner to the time stage
  typedef struct packed {
    logic                        accepted;
    logic [TIME_DIGITS-1:0][3:0] digits;
  } summary_t;

  function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h24; // $
      3'd1:    b = 8'h47; // G
      3'd2:    b = 8'h50; // P
      3'd3:    b = 8'h52; // R
      3'd4:    b = 8'h4D; // M
      3'd5:    b = 8'h43; // C
      3'd6:    b = CH_COMMA;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] t;
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
      r = {1'b1, t[3:0]};
    end else if (c >= CH_UA && c <= CH_UF) begin
      t = c - CH_UA + 8'd10;
      r = {1'b1, t[3:0]};
    end else if (c >= CH_LA && c <= CH_LF) begin
      t = c - CH_LA + 8'd10;
      r = {1'b1, t[3:0]};
    end
    return r;
  endfunction

endpackage

### design/nrmc_front.sv
// Byte scanner: header, checksum, status and time digits of one sentence.
module nrmc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        char_code,
  input  logic              last_char,
  output logic              push,
  output nrmc_pkg::summary_t push_data
);

  logic [3:0] pos, pos_next;
  logic       header_ok, header_ok_next;
  logic [1:0] comma_count, comma_count_next;
  logic [7:0] running_xor, running_xor_next;
  logic       star_seen, star_seen_next;
  logic [7:0] hex_value, hex_value_next;
  logic       hex_overflow, hex_overflow_next;
  logic       hex_stopped, hex_stopped_next;
  logic       status_active, status_active_next;
  logic [nrmc_pkg::TIME_DIGITS-1:0][3:0] digits, digits_next;
  logic [4:0] nib;
  logic [7:0] dsub;
  logic       is_dec;

  always_comb begin
    header_ok_next     = header_ok;
    comma_count_next   = comma_count;
    running_xor_next   = running_xor;
    star_seen_next     = star_seen;
    hex_value_next     = hex_value;
    hex_overflow_next  = hex_overflow;
    hex_stopped_next   = hex_stopped;
    status_active_next = status_active;
    digits_next        = digits;
    nib    = nrmc_pkg::hex_nibble(char_code);
    is_dec = (char_code >= nrmc_pkg::CH_ZERO) && (char_code <= nrmc_pkg::CH_NINE);
    dsub   = char_code - nrmc_pkg::CH_ZERO;

    if (pos < 4'(nrmc_pkg::HDR_LEN) && char_code != nrmc_pkg::hdr_byte(pos[2:0]))
      header_ok_next = 1'b0;

    for (int i = 0; i < nrmc_pkg::TIME_DIGITS; i++) begin
      if (pos == 4'(nrmc_pkg::TIME_FIRST + i))
        digits_next[i] = is_dec ? dsub[3:0] : 4'd0;
    end

    if (!star_seen) begin
      if (char_code == nrmc_pkg::CH_STAR) star_seen_next = 1'b1;
      else if (pos != 4'd0) running_xor_next = running_xor ^ char_code;
    end else if (!hex_stopped) begin
      if (!nib[4]) begin
        hex_stopped_next = 1'b1;
      end else begin
        if (hex_value[7:4] != 4'd0) hex_overflow_next = 1'b1;
        hex_value_next = {hex_value[3:0], nib[3:0]};
      end
    end

    if (comma_count == nrmc_pkg::CC_STATUS) begin
      status_active_next = (char_code == nrmc_pkg::CH_ACTIVE);
      comma_count_next   = nrmc_pkg::CC_DONE;
    end else if (comma_count < nrmc_pkg::CC_STATUS && char_code == nrmc_pkg::CH_COMMA) begin
      comma_count_next = comma_count + 2'd1;
    end

    pos_next = (pos < nrmc_pkg::POS_MAX) ? pos + 4'd1 : nrmc_pkg::POS_MAX;
  end

  // summary as of this byte; time digits not yet received read as zero
  always_comb begin
    push_data.accepted = header_ok_next && pos_next >= 4'(nrmc_pkg::HDR_LEN) &&
                         star_seen_next && !hex_overflow_next &&
                         hex_value_next == running_xor_next && status_active_next;
    for (int i = 0; i < nrmc_pkg::TIME_DIGITS; i++)
      push_data.digits[i] = (4'(nrmc_pkg::TIME_FIRST + i) < pos_next) ?
                            digits_next[i] : 4'd0;
  end

  assign push = take && last_char;

  always_ff @(posedge clk) begin
    if (rst || (take && last_char)) begin
      pos           <= 4'd0;
      header_ok     <= 1'b1;
      comma_count   <= 2'd0;
      running_xor   <= 8'd0;
      star_seen     <= 1'b0;
      hex_value     <= 8'd0;
      hex_overflow  <= 1'b0;
      hex_stopped   <= 1'b0;
      status_active <= 1'b0;
    end else if (take) begin
      pos           <= pos_next;
      header_ok     <= header_ok_next;
      comma_count   <= comma_count_next;
      running_xor   <= running_xor_next;
      star_seen     <= star_seen_next;
      hex_value     <= hex_value_next;
      hex_overflow  <= hex_overflow_next;
      hex_stopped   <= hex_stopped_next;
      status_active <= status_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) digits <= digits_next;
  end

endmodule

### design/nrmc_queue.sv
// Two-entry queue of sentence summaries between scanner and time stage.
module nrmc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  nrmc_pkg::summary_t push_data,
  output logic               full,
  output logic               not_empty,
  input  logic               pop,
  output nrmc_pkg::summary_t pop_data
);

  nrmc_pkg::summary_t entries [nrmc_pkg::QUEUE_DEPTH];
  logic [nrmc_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [nrmc_pkg::QCNT_W-1:0] count;

  assign full      = (count == nrmc_pkg::QCNT_W'(nrmc_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("summary pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("summary popped from empty queue");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count lost a push");
`endif

endmodule

### design/nrmc_back.sv
// Time stage: updates the held UTC time and forms the local-time result.
module nrmc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [4:0]         zone_offset_hours,
  input  logic               not_empty,
  input  nrmc_pkg::summary_t pop_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               sentence_accepted,
  output logic [4:0]         local_hours,
  output logic [5:0]         local_minutes,
  output logic [5:0]         local_seconds
);

  logic [4:0] held_hours, held_hours_next;
  logic [5:0] held_minutes, held_minutes_next;
  logic [5:0] held_seconds, held_seconds_next;
  logic [6:0] hr_raw, mn_raw, sc_raw;
  logic [5:0] sum;
  logic [4:0] local_next;

  assign pop = not_empty && (!out_valid || !out_stall);

  always_comb begin
    hr_raw = 7'(pop_data.digits[0]) * 7'd10 + 7'(pop_data.digits[1]);
    mn_raw = 7'(pop_data.digits[2]) * 7'd10 + 7'(pop_data.digits[3]);
    sc_raw = 7'(pop_data.digits[4]) * 7'd10 + 7'(pop_data.digits[5]);
    held_hours_next   = held_hours;
    held_minutes_next = held_minutes;
    held_seconds_next = held_seconds;
    if (pop_data.accepted) begin
      // two-digit hour is at most 99
      if (hr_raw >= 7'd96)      held_hours_next = 5'(hr_raw - 7'd96);
      else if (hr_raw >= 7'd72) held_hours_next = 5'(hr_raw - 7'd72);
      else if (hr_raw >= 7'd48) held_hours_next = 5'(hr_raw - 7'd48);
      else if (hr_raw >= 7'd24) held_hours_next = 5'(hr_raw - 7'd24);
      else                      held_hours_next = hr_raw[4:0];
      held_minutes_next = (mn_raw > 7'd59) ? 6'd59 : mn_raw[5:0];
      held_seconds_next = (sc_raw > 7'd59) ? 6'd59 : sc_raw[5:0];
    end
    sum = 6'(held_hours_next) + 6'(zone_offset_hours);
    if (sum >= 6'd48)      local_next = 5'(sum - 6'd48);
    else if (sum >= 6'd24) local_next = 5'(sum - 6'd24);
    else                   local_next = sum[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      held_hours   <= 5'd0;
      held_minutes <= 6'd0;
      held_seconds <= 6'd0;
    end else begin
      if (pop) begin
        out_valid    <= 1'b1;
        held_hours   <= held_hours_next;
        held_minutes <= held_minutes_next;
        held_seconds <= held_seconds_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sentence_accepted <= pop_data.accepted;
      local_hours       <= local_next;
      local_minutes     <= held_minutes_next;
      local_seconds     <= held_seconds_next;
    end
  end

endmodule

### design/nmea_rmc_checksum_time_parser.sv
// Top level of the RMC sentence checksum and local-time parser.
// Takes one sentence byte per cycle; the scanner never holds a byte back
// unless the two-entry summary queue is full, which happens only when the
// result port has been stalled. Once the byte flagged last_char is taken,
// its summary is written into the queue and then popped into the time stage
// output register, which raises out_valid. The held time starts at 00:00:00
// UTC and the zone offset resets to 8 hours; write zone_offset_hours only
// while no sentence is pending.
module nmea_rmc_checksum_time_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       last_char,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       sentence_accepted,
  output logic [4:0] local_hours,
  output logic [5:0] local_minutes,
  output logic [5:0] local_seconds
);

  logic               take, push, full, not_empty, pop;
  nrmc_pkg::summary_t push_data, pop_data;
  logic [4:0]         zone_offset_hours;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign take      = in_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) zone_offset_hours <= nrmc_pkg::ZONE_RESET;
    else if (cfg_valid && cfg_ready) zone_offset_hours <= cfg_data;
  end

  nrmc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .char_code (char_code),
    .last_char (last_char),
    .push      (push),
    .push_data (push_data)
  );

  nrmc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .not_empty (not_empty),
    .pop       (pop),
    .pop_data  (pop_data)
  );

  nrmc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .zone_offset_hours (zone_offset_hours),
    .not_empty         (not_empty),
    .pop_data          (pop_data),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .sentence_accepted (sentence_accepted),
    .local_hours       (local_hours),
    .local_minutes     (local_minutes),
    .local_seconds     (local_seconds)
  );

endmodule

### verif/tb_nmea_rmc_checksum_time_parser.sv
// Testbench for the RMC checksum and local-time parser: directed and random sentences.
module tb_nmea_rmc_checksum_time_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 2;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BYTES = 290;
  localparam string RMC_HDR = "$GPRMC,";
  localparam string FIELD_CHARS = "0123456789.,NSEWV";

  typedef logic [7:0] octet_t;

  typedef struct packed {
    logic       accepted;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } time_report_t;

  class rmc_scoreboard;
    time_report_t expected_q[$];
    logic [4:0] zone;
    int mismatches;
    int pos, commas;
    bit hdr_ok, star, hex_stop, ovf, status;
    logic [7:0] xsum, hexv;
    int digit[6];
    int held_h, held_m, held_s;

    function new();
      zone = nrmc_pkg::ZONE_RESET;
      mismatches = 0;
      held_h = 0;
      held_m = 0;
      held_s = 0;
      clear_sentence();
    endfunction

    function void clear_sentence();
      pos = 0;
      hdr_ok = 1;
      commas = 0;
      xsum = 0;
      star = 0;
      hexv = 0;
      ovf = 0;
      hex_stop = 0;
      status = 0;
    endfunction

    function int hex_val(octet_t c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "F") return c - "A" + 10;
      if (c >= "a" && c <= "f") return c - "a" + 10;
      return -1;
    endfunction

    // one accepted byte; a flagged last byte yields one time report
    function void note_byte(octet_t c, bit last);
      int h, i;
      int d[6];
      bit ok;
      time_report_t r;
      if (pos < 7 && c != RMC_HDR[pos]) hdr_ok = 0;
      if (pos >= 7 && pos < 13) digit[pos - 7] = (c >= "0" && c <= "9") ? c - "0" : 0;
      if (!star) begin
        if (c == nrmc_pkg::CH_STAR) star = 1;
        else if (pos >= 1) xsum ^= c;
      end else if (!hex_stop) begin
        h = hex_val(c);
        if (h < 0) begin
          hex_stop = 1;
        end else begin
          if (hexv >= 16) ovf = 1;
          hexv = {hexv[3:0], h[3:0]};
        end
      end
      if (commas == 2) begin
        status = (c == nrmc_pkg::CH_ACTIVE);
        commas = 3;
      end else if (commas < 2 && c == nrmc_pkg::CH_COMMA) begin
        commas++;
      end
      if (pos < 15) pos++;
      if (!last) return;
      ok = hdr_ok && pos >= 7 && star && !ovf && hexv == xsum && status;
      if (ok) begin
        // digits past the end of a short sentence read as zero
        for (i = 0; i < 6; i++) d[i] = (7 + i < pos) ? digit[i] : 0;
        held_h = (d[0] * 10 + d[1]) % 24;
        held_m = (d[2] * 10 + d[3] > 59) ? 59 : d[2] * 10 + d[3];
        held_s = (d[4] * 10 + d[5] > 59) ? 59 : d[4] * 10 + d[5];
      end
      r.accepted = ok;
      r.hours = 5'((held_h + zone) % 24);
      r.minutes = 6'(held_m);
      r.seconds = 6'(held_s);
      expected_q.push_back(r);
      clear_sentence();
    endfunction

    function void check_result(time_report_t got);
      time_report_t want;
      if (expected_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: report with no sentence pending: accepted=%0b %0d:%0d:%0d",
                   $time, got.accepted, got.hours, got.minutes, got.seconds);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.accepted !== want.accepted || got.hours !== want.hours ||
          got.minutes !== want.minutes || got.seconds !== want.seconds) begin
        if (mismatches < 10)
          $display("%0t: report mismatch: expected accepted=%0b %0d:%0d:%0d, got accepted=%0b %0d:%0d:%0d",
                   $time, want.accepted, want.hours, want.minutes, want.seconds,
                   got.accepted, got.hours, got.minutes, got.seconds);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  octet_t char_code = 8'h00;
  logic last_char = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [4:0] cfg_data = 5'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic sentence_accepted;
  logic [4:0] local_hours;
  logic [5:0] local_minutes;
  logic [5:0] local_seconds;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;
  rmc_scoreboard board = new;

  nmea_rmc_checksum_time_parser dut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

  always @(posedge clk) begin
    if (out_valid && !out_stall)
      board.check_result({sentence_accepted, local_hours, local_minutes, local_seconds});
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void push_str(ref octet_t q[$], input string s);
    int i;
    for (i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  // XOR of everything after the leading byte
  function automatic octet_t body_xor(input octet_t q[$]);
    octet_t x;
    int i;
    x = 8'h00;
    for (i = 1; i < q.size(); i++) x ^= q[i];
    return x;
  endfunction

  function automatic octet_t hex_char(input logic [3:0] n, input bit lower);
    if (n < 10) return octet_t'("0" + n);
    return octet_t'((lower ? "a" : "A") + n - 10);
  endfunction

  // random sentence: mostly well formed, the rest broken in one way or plain noise
  function automatic void gen_sentence(ref octet_t q[$]);
    int kind, n;
    octet_t cks;
    q.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 94) begin
      n = $urandom_range(1, 24);
      repeat (n) q.push_back(octet_t'($urandom_range(0, 255)));
      return;
    end
    push_str(q, RMC_HDR);
    if (kind >= 90) begin
      q = q[0:$urandom_range(0, 5)];
      return;
    end
    if (kind >= 86) q[$urandom_range(0, 6)] = octet_t'($urandom_range(0, 255));
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : 6;
    repeat (n) begin
      if ($urandom_range(0, 15) == 0) q.push_back(octet_t'($urandom_range("G", "Z")));
      else q.push_back(octet_t'($urandom_range("0", "9")));
    end
    if ($urandom_range(0, 1)) push_str(q, ".00");
    // 82..85: no second comma
    if (kind < 82 || kind >= 86) begin
      q.push_back(nrmc_pkg::CH_COMMA);
      q.push_back((kind >= 78 && kind < 82) ? octet_t'($urandom_range("B", "Z"))
                                             : nrmc_pkg::CH_ACTIVE);
      n = $urandom_range(0, 10);
      repeat (n) q.push_back(FIELD_CHARS[$urandom_range(0, FIELD_CHARS.len() - 1)]);
    end
    // 74..77: no star at all
    if (kind < 74 || kind >= 78) begin
      cks = body_xor(q);
      if (kind >= 70 && kind < 74) cks ^= octet_t'($urandom_range(1, 255));
      q.push_back(nrmc_pkg::CH_STAR);
      if (kind >= 66 && kind < 70) q.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
      if (kind < 63 || kind >= 66) begin
        q.push_back(hex_char(cks[7:4], $urandom_range(0, 1)));
        q.push_back(hex_char(cks[3:0], $urandom_range(0, 1)));
      end
    end
    case ($urandom_range(0, 3))
      1: push_str(q, "\015\012");
      2: begin
        q.push_back(8'h0D);
        n = $urandom_range(1, 4);
        repeat (n) q.push_back(octet_t'($urandom_range(0, 255)));
      end
      default: ;
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_byte(input octet_t b, input bit last);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    char_code <= b;
    last_char <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_byte(b, last);
    @(negedge clk);
  endtask

  task automatic send_sentence(input octet_t q[$]);
    int i;
    for (i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic send_raw(input string s);
    octet_t q[$];
    push_str(q, s);
    send_sentence(q);
  endtask

  task automatic send_framed(input string body, input string hex_pre, input octet_t flip,
                             input bit lower, input string tail);
    octet_t q[$];
    octet_t x;
    q.push_back("$");
    push_str(q, body);
    x = body_xor(q) ^ flip;
    q.push_back(nrmc_pkg::CH_STAR);
    push_str(q, hex_pre);
    q.push_back(hex_char(x[7:4], lower));
    q.push_back(hex_char(x[3:0], lower));
    push_str(q, tail);
    send_sentence(q);
  endtask

  task automatic drain();
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_zone(input logic [4:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.zone = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int idle_pct, input int stall_pct, input int nbytes);
    octet_t q[$];
    int sent;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < nbytes) begin
      gen_sentence(q);
      send_sentence(q);
      sent += q.size();
    end
    in_valid <= 1'b0;
    drain();
  endtask

  initial begin
    octet_t q[$];
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_framed("GPRMC,235959,A", "", 8'h00, 1'b0, "\015\012");
    // hour wraps mod 24, minutes and seconds clamp
    send_framed("GPRMC,999999.00,A,4916.45,N", "", 8'h00, 1'b1, "");
    send_framed("GPRMC,1x3:5Z,A", "", 8'h00, 1'b0, "");
    send_raw("$GP");
    send_raw("$GPRMC,010203,A,0");
    send_framed("GPRMC,040506,A", "7", 8'h00, 1'b0, "");
    send_framed("GPRMC,040506,A", "0", 8'h00, 1'b1, "");
    // checksum of zero with no hex digits after the star
    push_str(q, "$GPRMC,070809,A,");
    q.push_back(body_xor(q) ^ 8'h80);
    q.push_back(8'h80);
    q.push_back(nrmc_pkg::CH_STAR);
    q.push_back(8'h0D);
    send_sentence(q);
    send_framed("GPRMC,111111,V", "", 8'h00, 1'b0, "");
    send_framed("GPRMC,121314.5", "", 8'h00, 1'b0, "");
    send_framed("GPRMC,131415,A", "", 8'h5A, 1'b1, "");
    // junk after the checksum must not count
    send_framed("GPRMC,202122,A,,,", "", 8'h00, 1'b0, "\015AB*9");
    send_framed("GPRMC,,A", "", 8'h00, 1'b0, "");
    send_framed("GPRMC,12,A", "", 8'h00, 1'b1, "");
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    in_valid <= 1'b0;
    drain();

    write_zone(5'd0);
    run_random(66, 0, PHASE_BYTES);
    write_zone(5'd23);
    run_random(0, 66, PHASE_BYTES);
    write_zone(5'd31);
    run_random(20, 20, PHASE_BYTES);
    write_zone(5'($urandom_range(1, 22)));
    run_random(0, 0, PHASE_BYTES);

    if (board.mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
